@@ hw/rtl/pvb_pkg.sv @@
package pvb_pkg;

   localparam int CHAN_BITS = 8;
   localparam int INV_BITS = 17;
   localparam int SQ_BITS = 17;
   localparam int HALF_BITS = 15;
   localparam int SQ_SHIFT = 14;
   localparam int FRAC_BITS = 16;
   localparam int MIX_BITS = 16;
   localparam int WEIGHT_BITS = 8;
   localparam int X_BITS = 32;
   localparam int SEARCH_STAGES = 4;
   localparam int SEARCH_STEPS = WEIGHT_BITS / SEARCH_STAGES;
   localparam int THRESHOLD_COUNT = 1 << WEIGHT_BITS;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [INV_BITS-1:0] INV_RESET = 17'd16;
   localparam logic [SQ_BITS-1:0] ONE_Q16 = 17'h10000;
   localparam int HALF_Q16 = 32768;
   localparam logic [FRAC_BITS-1:0] M_MAX = 16'hFFFF;
   localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'hFF;
   localparam logic [MIX_BITS-1:0] MIX_ROUND = 16'd127;

   typedef enum logic [CSR_ADDR_BITS-3:0] {
      CSR_INVERSE_WIDTH  = 3'd0,
      CSR_INVERSE_HEIGHT = 3'd1,
      CSR_TINT_RED       = 3'd2,
      CSR_TINT_GREEN     = 3'd3,
      CSR_TINT_BLUE      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] alpha;
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] alpha;
      logic [MIX_BITS-1:0]  red;
      logic [MIX_BITS-1:0]  green;
      logic [MIX_BITS-1:0]  blue;
   } mix_type;

   typedef logic [X_BITS-1:0] threshold_table_type [THRESHOLD_COUNT];

   // weight k is reached once x >= ((2k-1)/510)^10, all in q0.32
   function automatic threshold_table_type build_thresholds();
      threshold_table_type tab;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] t4;
      logic [63:0] t8;
      logic [63:0] t10;
      tab[0] = '0;
      for (int k = 1; k < THRESHOLD_COUNT; k++) begin
         t = (64'(2 * k - 1) << 32) / 64'd510;
         t2 = (t * t) >> 32;
         t4 = (t2 * t2) >> 32;
         t8 = (t4 * t4) >> 32;
         t10 = (t8 * t2) >> 32;
         tab[k] = t10[X_BITS-1:0];
      end
      return tab;
   endfunction

   localparam threshold_table_type CURVE_THRESHOLD = build_thresholds();

endpackage

@@ hw/rtl/pvb_curve_search.sv @@
module pvb_curve_search #(
   parameter int INDEX_BITS = 10
) (
   input  logic                               clock,
   input  logic [pvb_pkg::SEARCH_STAGES-1:0]  advance,
   input  logic [INDEX_BITS-1:0]              index_in,
   output logic [pvb_pkg::WEIGHT_BITS-1:0]    weight_out
);

   logic [pvb_pkg::WEIGHT_BITS-1:0] n_ff [pvb_pkg::SEARCH_STAGES];
   logic [pvb_pkg::X_BITS-1:0]      x_ff [pvb_pkg::SEARCH_STAGES-1];
   logic [pvb_pkg::X_BITS-1:0]      x_first;

   assign x_first = {index_in, {(pvb_pkg::X_BITS - INDEX_BITS){1'b0}}};

   // binary search over the sorted thresholds, two weight bits per stage
   for (genvar j = 0; j < pvb_pkg::SEARCH_STAGES; j++) begin : g_stage
      logic [pvb_pkg::WEIGHT_BITS-1:0] n_src;
      logic [pvb_pkg::X_BITS-1:0]      x_src;
      logic [pvb_pkg::WEIGHT_BITS-1:0] n_in;

      if (j == 0) begin : g_first
         assign n_src = '0;
         assign x_src = x_first;
      end else begin : g_next
         assign n_src = n_ff[j-1];
         assign x_src = x_ff[j-1];
      end

      always_comb begin : p_step
         logic [pvb_pkg::WEIGHT_BITS-1:0] cand;
         n_in = n_src;
         for (int s = 0; s < pvb_pkg::SEARCH_STEPS; s++) begin
            cand = n_in | (pvb_pkg::WEIGHT_BITS'(1)
                   << (pvb_pkg::WEIGHT_BITS - 1 - pvb_pkg::SEARCH_STEPS * j - s));
            if (pvb_pkg::CURVE_THRESHOLD[cand] <= x_src) begin
               n_in = cand;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (advance[j]) begin
            n_ff[j] <= n_in;
         end
      end

      if (j < pvb_pkg::SEARCH_STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance[j]) begin
               x_ff[j] <= x_src;
            end
         end
      end
   end

   assign weight_out = n_ff[pvb_pkg::SEARCH_STAGES-1];

endmodule

@@ hw/rtl/pixel_vignette_blend.sv @@
// pipeline: nine register stages, from scaled coordinates through curve search
// and mix to the divided result on rsp_; one request per clock while rsp_stall
// is low; every stage holds a valid bit and fills any empty slot downstream of
// it, so a held output still lets requests in until every slot is full
// reset: valid bits clear, inverse width/height return to 16, tint to zero
module pixel_vignette_blend #(
   parameter int COORD_BITS = 12,
   parameter int CURVE_INDEX_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [COORD_BITS-1:0]               req_column,
   input  logic [COORD_BITS-1:0]               req_row,
   input  logic [pvb_pkg::CHAN_BITS-1:0]       req_in_alpha,
   input  logic [pvb_pkg::CHAN_BITS-1:0]       req_in_red,
   input  logic [pvb_pkg::CHAN_BITS-1:0]       req_in_green,
   input  logic [pvb_pkg::CHAN_BITS-1:0]       req_in_blue,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pvb_pkg::CHAN_BITS-1:0]       rsp_out_alpha,
   output logic [pvb_pkg::CHAN_BITS-1:0]       rsp_out_red,
   output logic [pvb_pkg::CHAN_BITS-1:0]       rsp_out_green,
   output logic [pvb_pkg::CHAN_BITS-1:0]       rsp_out_blue,

   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pvb_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [pvb_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [pvb_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   localparam int STAGES = 9;
   localparam int ST_SQUARE = 1;
   localparam int ST_INDEX = 2;
   localparam int ST_SEARCH = 3;
   localparam int ST_MIX = ST_SEARCH + pvb_pkg::SEARCH_STAGES;
   localparam int ST_OUT = ST_MIX + 1;
   localparam int PROD_BITS = COORD_BITS + pvb_pkg::INV_BITS;
   localparam int M_FULL_BITS = 2 * pvb_pkg::SQ_BITS;

   // configuration registers
   logic [pvb_pkg::INV_BITS-1:0]  inv_width_ff;
   logic [pvb_pkg::INV_BITS-1:0]  inv_height_ff;
   logic [pvb_pkg::CHAN_BITS-1:0] tint_red_ff;
   logic [pvb_pkg::CHAN_BITS-1:0] tint_green_ff;
   logic [pvb_pkg::CHAN_BITS-1:0] tint_blue_ff;
   logic                          csr_write;
   pvb_pkg::csr_index_type        csr_index;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = pvb_pkg::csr_index_type'(csr_paddr[pvb_pkg::CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_width_ff <= pvb_pkg::INV_RESET;
         inv_height_ff <= pvb_pkg::INV_RESET;
         tint_red_ff <= '0;
         tint_green_ff <= '0;
         tint_blue_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            pvb_pkg::CSR_INVERSE_WIDTH: begin
               inv_width_ff <= csr_pwdata[pvb_pkg::INV_BITS-1:0];
            end
            pvb_pkg::CSR_INVERSE_HEIGHT: begin
               inv_height_ff <= csr_pwdata[pvb_pkg::INV_BITS-1:0];
            end
            pvb_pkg::CSR_TINT_RED: begin
               tint_red_ff <= csr_pwdata[pvb_pkg::CHAN_BITS-1:0];
            end
            pvb_pkg::CSR_TINT_GREEN: begin
               tint_green_ff <= csr_pwdata[pvb_pkg::CHAN_BITS-1:0];
            end
            pvb_pkg::CSR_TINT_BLUE: begin
               tint_blue_ff <= csr_pwdata[pvb_pkg::CHAN_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         pvb_pkg::CSR_INVERSE_WIDTH:  csr_prdata = pvb_pkg::CSR_DATA_BITS'(inv_width_ff);
         pvb_pkg::CSR_INVERSE_HEIGHT: csr_prdata = pvb_pkg::CSR_DATA_BITS'(inv_height_ff);
         pvb_pkg::CSR_TINT_RED:       csr_prdata = pvb_pkg::CSR_DATA_BITS'(tint_red_ff);
         pvb_pkg::CSR_TINT_GREEN:     csr_prdata = pvb_pkg::CSR_DATA_BITS'(tint_green_ff);
         pvb_pkg::CSR_TINT_BLUE:      csr_prdata = pvb_pkg::CSR_DATA_BITS'(tint_blue_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // pipeline control
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] advance;

   always_comb begin
      advance[STAGES-1] = !valid_ff[STAGES-1] || !rsp_stall;
      for (int i = STAGES - 2; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
      valid_in[0] = advance[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < STAGES; i++) begin
         valid_in[i] = advance[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !advance[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // pixel channels ride along until the mix stage
   pvb_pkg::pixel_type pix_ff [ST_MIX];
   pvb_pkg::pixel_type pix_in;

   assign pix_in = '{alpha: req_in_alpha, red: req_in_red,
                     green: req_in_green, blue: req_in_blue};

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         pix_ff[0] <= pix_in;
      end
      for (int i = 1; i < ST_MIX; i++) begin
         if (advance[i]) begin
            pix_ff[i] <= pix_ff[i-1];
         end
      end
   end

   // stage 0: scaled coordinates
   logic [PROD_BITS-1:0] pu_ff;
   logic [PROD_BITS-1:0] pv_ff;
   logic [PROD_BITS-1:0] pu_in;
   logic [PROD_BITS-1:0] pv_in;

   assign pu_in = PROD_BITS'(req_column) * PROD_BITS'(inv_width_ff);
   assign pv_in = PROD_BITS'(req_row) * PROD_BITS'(inv_height_ff);

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         pu_ff <= pu_in;
         pv_ff <= pv_in;
      end
   end

   // stage 1: 4*offset^2 in q1.16, saturating at 1.0
   function automatic logic [pvb_pkg::SQ_BITS-1:0] square_term(
      input logic [PROD_BITS-1:0] p
   );
      logic [PROD_BITS-1:0]             a;
      logic [2*pvb_pkg::HALF_BITS-1:0]  sq;
      a = (p >= PROD_BITS'(pvb_pkg::HALF_Q16)) ? p - PROD_BITS'(pvb_pkg::HALF_Q16)
                                               : PROD_BITS'(pvb_pkg::HALF_Q16) - p;
      sq = a[pvb_pkg::HALF_BITS-1:0] * a[pvb_pkg::HALF_BITS-1:0];
      if (a >= PROD_BITS'(pvb_pkg::HALF_Q16)) begin
         return pvb_pkg::ONE_Q16;
      end
      return pvb_pkg::SQ_BITS'(sq >> pvb_pkg::SQ_SHIFT);
   endfunction

   logic [pvb_pkg::SQ_BITS-1:0] su_ff;
   logic [pvb_pkg::SQ_BITS-1:0] sv_ff;
   logic [pvb_pkg::SQ_BITS-1:0] su_in;
   logic [pvb_pkg::SQ_BITS-1:0] sv_in;

   assign su_in = square_term(pu_ff);
   assign sv_in = square_term(pv_ff);

   always_ff @(posedge clock) begin
      if (advance[ST_SQUARE]) begin
         su_ff <= su_in;
         sv_ff <= sv_in;
      end
   end

   // stage 2: strength product and curve index
   logic [M_FULL_BITS-1:0]            m_full;
   logic [M_FULL_BITS-1:0]            m_shift;
   logic [pvb_pkg::FRAC_BITS-1:0]     m_sat;
   logic [CURVE_INDEX_BITS-1:0]       idx_ff;
   logic [CURVE_INDEX_BITS-1:0]       idx_in;

   assign m_full = M_FULL_BITS'(su_ff) * M_FULL_BITS'(sv_ff);
   assign m_shift = m_full >> pvb_pkg::FRAC_BITS;
   assign m_sat = (m_shift > M_FULL_BITS'(pvb_pkg::M_MAX)) ? pvb_pkg::M_MAX
                                                           : m_shift[pvb_pkg::FRAC_BITS-1:0];
   assign idx_in = m_sat[pvb_pkg::FRAC_BITS-1 -: CURVE_INDEX_BITS];

   always_ff @(posedge clock) begin
      if (advance[ST_INDEX]) begin
         idx_ff <= idx_in;
      end
   end

   // stages 3 to 6: curve lookup
   logic [pvb_pkg::WEIGHT_BITS-1:0] weight;

   pvb_curve_search #(
      .INDEX_BITS (CURVE_INDEX_BITS)
   ) u_search (
      .clock      (clock),
      .advance    (advance[ST_MIX-1:ST_SEARCH]),
      .index_in   (idx_ff),
      .weight_out (weight)
   );

   // stage 7: weighted sums
   function automatic logic [pvb_pkg::MIX_BITS-1:0] blend_sum(
      input logic [pvb_pkg::CHAN_BITS-1:0]   c,
      input logic [pvb_pkg::CHAN_BITS-1:0]   tint,
      input logic [pvb_pkg::WEIGHT_BITS-1:0] w
   );
      return pvb_pkg::MIX_BITS'(c) * pvb_pkg::MIX_BITS'(pvb_pkg::CHAN_MAX - w)
           + pvb_pkg::MIX_BITS'(tint) * pvb_pkg::MIX_BITS'(w) + pvb_pkg::MIX_ROUND;
   endfunction

   pvb_pkg::mix_type mix_ff;
   pvb_pkg::mix_type mix_in;

   assign mix_in = '{alpha: pix_ff[ST_MIX-1].alpha,
                     red:   blend_sum(pix_ff[ST_MIX-1].red, tint_red_ff, weight),
                     green: blend_sum(pix_ff[ST_MIX-1].green, tint_green_ff, weight),
                     blue:  blend_sum(pix_ff[ST_MIX-1].blue, tint_blue_ff, weight)};

   always_ff @(posedge clock) begin
      if (advance[ST_MIX]) begin
         mix_ff <= mix_in;
      end
   end

   // stage 8: divide by 255, exact for sums up to 65279
   function automatic logic [pvb_pkg::CHAN_BITS-1:0] div255(
      input logic [pvb_pkg::MIX_BITS-1:0] v
   );
      logic [pvb_pkg::MIX_BITS-1:0] t;
      t = v + (v >> pvb_pkg::CHAN_BITS) + pvb_pkg::MIX_BITS'(1);
      return t[pvb_pkg::MIX_BITS-1 -: pvb_pkg::CHAN_BITS];
   endfunction

   pvb_pkg::pixel_type out_ff;
   pvb_pkg::pixel_type out_in;

   assign out_in = '{alpha: mix_ff.alpha,
                     red:   div255(mix_ff.red),
                     green: div255(mix_ff.green),
                     blue:  div255(mix_ff.blue)};

   always_ff @(posedge clock) begin
      if (advance[ST_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_out_alpha = out_ff.alpha;
   assign rsp_out_red = out_ff.red;
   assign rsp_out_green = out_ff.green;
   assign rsp_out_blue = out_ff.blue;

`ifndef SYNTHESIS
   a_gap_admits_request: assert property (@(posedge clock) disable iff (reset)
      !(&valid_ff) |-> !req_stall)
      else $error("request stalled while a pipeline slot is empty");

   a_fill_count: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !(rsp_valid && !rsp_stall))
      |=> $countones(valid_ff) == $past($countones(valid_ff)) + 1)
      else $error("accepted request not held in the pipeline");

   a_drain_count: assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && !req_stall) && rsp_valid && !rsp_stall)
      |=> $countones(valid_ff) == $past($countones(valid_ff)) - 1)
      else $error("delivered result not removed from the pipeline");
`endif

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int COORD_W = 12;
   localparam int INDEX_W = 10;
   localparam int CURVE_ENTRIES = 1 << INDEX_W;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 16;
   localparam logic [pvb_pkg::CSR_ADDR_BITS-3:0] UNMAPPED_LOW = 3'd5;
   localparam logic [pvb_pkg::CSR_ADDR_BITS-3:0] UNMAPPED_HIGH = 3'd7;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } argb_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [COORD_W-1:0]        req_column = '0;
   logic [COORD_W-1:0]        req_row = '0;
   logic [7:0]                req_in_alpha = '0;
   logic [7:0]                req_in_red = '0;
   logic [7:0]                req_in_green = '0;
   logic [7:0]                req_in_blue = '0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [7:0]                rsp_out_alpha;
   logic [7:0]                rsp_out_red;
   logic [7:0]                rsp_out_green;
   logic [7:0]                rsp_out_blue;

   logic                                  csr_psel = 1'b0;
   logic                                  csr_penable = 1'b0;
   logic                                  csr_pwrite = 1'b0;
   logic [pvb_pkg::CSR_ADDR_BITS-1:0]     csr_paddr = '0;
   logic [pvb_pkg::CSR_DATA_BITS-1:0]     csr_pwdata = '0;
   logic [pvb_pkg::CSR_DATA_BITS-1:0]     csr_prdata;
   logic                                  csr_pready;

   logic [16:0] inv_width_q16 = 17'd16;
   logic [16:0] inv_height_q16 = 17'd16;
   logic [7:0]  tint_r = 8'd0;
   logic [7:0]  tint_g = 8'd0;
   logic [7:0]  tint_b = 8'd0;

   logic [7:0]  weight_curve [CURVE_ENTRIES];
   argb_type    blended_pixels [$];

   int send_gap_pct = 0;
   int stall_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   pixel_vignette_blend #(
      .COORD_BITS(COORD_W),
      .CURVE_INDEX_BITS(INDEX_W)
   ) DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // weight k is reached once the strength passes ((2k-1)/510)^10 in q0.32
   function automatic void build_weight_curve();
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] t4;
      logic [63:0] t8;
      logic [63:0] x;
      logic [63:0] level [256];
      int n;
      for (int k = 1; k < 256; k++) begin
         t = (64'(2 * k - 1) << 32) / 64'd510;
         t2 = (t * t) >> 32;
         t4 = (t2 * t2) >> 32;
         t8 = (t4 * t4) >> 32;
         level[k] = (t8 * t2) >> 32;
      end
      for (int i = 0; i < CURVE_ENTRIES; i++) begin
         x = 64'(i) << (32 - INDEX_W);
         n = 0;
         for (int k = 1; k < 256; k++) begin
            if (level[k] <= x) n++;
         end
         weight_curve[i] = 8'(n);
      end
   endfunction

   function automatic logic [16:0] offset_square(logic [COORD_W-1:0] coord, logic [16:0] inv);
      logic [31:0] p;
      logic [31:0] a;
      p = coord * inv;
      a = (p >= 32'd32768) ? p - 32'd32768 : 32'd32768 - p;
      if (a >= 32'd32768) return 17'h10000;
      return 17'((a * a) >> 14);
   endfunction

   function automatic logic [7:0] vignette_weight(logic [COORD_W-1:0] col,
                                                  logic [COORD_W-1:0] row);
      logic [33:0] m;
      m = (34'(offset_square(col, inv_width_q16)) * offset_square(row, inv_height_q16)) >> 16;
      if (m > 34'd65535) m = 34'd65535;
      return weight_curve[m >> (pvb_pkg::FRAC_BITS - INDEX_W)];
   endfunction

   function automatic logic [7:0] mix_channel(logic [7:0] c, logic [7:0] tint, logic [7:0] w);
      int unsigned sum;
      sum = 32'(c) * (32'd255 - 32'(w)) + 32'(tint) * 32'(w) + 32'd127;
      return 8'(sum / 32'd255);
   endfunction

   function automatic argb_type predict_blend(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                                              logic [7:0] a, logic [7:0] r,
                                              logic [7:0] g, logic [7:0] b);
      argb_type px;
      logic [7:0] w;
      w = vignette_weight(col, row);
      px.alpha = a;
      px.red = mix_channel(r, tint_r, w);
      px.green = mix_channel(g, tint_g, w);
      px.blue = mix_channel(b, tint_b, w);
      return px;
   endfunction

   function automatic void check_channel(string label, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      argb_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (blended_pixels.size() == 0) begin
            $display("%0t: result with no request pending, expected none, actual %h",
                     $time, {rsp_out_alpha, rsp_out_red, rsp_out_green, rsp_out_blue});
            mismatch_count++;
         end else begin
            want = blended_pixels.pop_front();
            check_channel("alpha", want.alpha, rsp_out_alpha);
            check_channel("red", want.red, rsp_out_red);
            check_channel("green", want.green, rsp_out_green);
            check_channel("blue", want.blue, rsp_out_blue);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("pixel_vignette_blend test failed");
         $finish;
      end
   end

   task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                             logic [7:0] a, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_column <= col;
      req_row <= row;
      req_in_alpha <= a;
      req_in_red <= r;
      req_in_green <= g;
      req_in_blue <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      blended_pixels.push_back(predict_blend(col, row, a, r, g, b));
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (blended_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [pvb_pkg::CSR_ADDR_BITS-3:0] index, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic release_bus();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_vignette(logic [31:0] inv_w, logic [31:0] inv_h,
                                   logic [31:0] red, logic [31:0] green, logic [31:0] blue);
      quiesce();
      write_register(pvb_pkg::CSR_INVERSE_WIDTH, inv_w);
      write_register(pvb_pkg::CSR_INVERSE_HEIGHT, inv_h);
      write_register(pvb_pkg::CSR_TINT_RED, red);
      write_register(pvb_pkg::CSR_TINT_GREEN, green);
      write_register(pvb_pkg::CSR_TINT_BLUE, blue);
      release_bus();
      inv_width_q16 = inv_w[16:0];
      inv_height_q16 = inv_h[16:0];
      tint_r = red[7:0];
      tint_g = green[7:0];
      tint_b = blue[7:0];
   endtask

   function automatic int pick_extent();
      case ($urandom_range(7))
         0: return $urandom_range(1, 3);
         1: return 4096;
         2: return $urandom_range(4, 64);
         3: return $urandom_range(65, 4096);
         default: return 320 * $urandom_range(1, 6);
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord(int extent);
      if (extent > 4096 || $urandom_range(99) < 15) return COORD_W'($urandom_range(4095));
      return COORD_W'($urandom_range(extent - 1));
   endfunction

   function automatic logic [31:0] pick_tint();
      case ($urandom_range(4))
         0: return 32'd0;
         1: return 32'd255;
         default: return $urandom_range(255);
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_pixel(12'd2048, 12'd2048, 8'hFF, 8'h12, 8'h34, 8'h56);
      send_pixel(12'd0, 12'd0, 8'h00, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(12'd4095, 12'd4095, 8'hA5, 8'h80, 8'h7F, 8'h01);
      send_pixel(12'd2048, 12'd0, 8'h5A, 8'hC0, 8'h40, 8'h20);
   endtask

   task automatic test_center_and_corners();
      program_vignette(65536 / 64, 65536 / 48, 255, 128, 0);
      send_pixel(12'd32, 12'd24, 8'h80, 8'h00, 8'hFF, 8'h55);
      send_pixel(12'd0, 12'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      send_pixel(12'd63, 12'd0, 8'h11, 8'h22, 8'h33, 8'h44);
      send_pixel(12'd0, 12'd47, 8'h99, 8'hAA, 8'hBB, 8'hCC);
      send_pixel(12'd63, 12'd47, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pixel(12'd0, 12'd24, 8'h3C, 8'h90, 8'h10, 8'hE0);
      send_pixel(12'd32, 12'd0, 8'hC3, 8'h6F, 8'hF6, 8'h0D);
      send_pixel(12'd40, 12'd30, 8'h7E, 8'h81, 8'h18, 8'hE7);
      send_pixel(12'd56, 12'd6, 8'h01, 8'hFE, 8'h02, 8'hFD);
   endtask

   task automatic test_beyond_frame();
      program_vignette(1024, 1024, 0, 255, 255);
      send_pixel(12'd4095, 12'd4095, 8'hFF, 8'h80, 8'h80, 8'h80);
      send_pixel(12'd64, 12'd10, 8'h10, 8'hFF, 8'h00, 8'h7F);
      send_pixel(12'd4095, 12'd0, 8'h20, 8'h00, 8'hFF, 8'h40);
      send_pixel(12'd2000, 12'd32, 8'h30, 8'h60, 8'h90, 8'hC0);
      program_vignette(32'h1FFFF, 32'h1FFFF, 255, 255, 255);
      send_pixel(12'd1, 12'd1, 8'h44, 8'h00, 8'h00, 8'h00);
      send_pixel(12'd0, 12'd0, 8'h55, 8'h10, 8'h20, 8'h30);
      send_pixel(12'd4095, 12'd4095, 8'h66, 8'hF0, 8'hE0, 8'hD0);
   endtask

   task automatic test_zero_inverse();
      program_vignette(0, 0, 10, 20, 30);
      send_pixel(12'd0, 12'd0, 8'h77, 8'hFF, 8'h00, 8'h80);
      send_pixel(12'd1234, 12'd567, 8'h88, 8'h40, 8'hC0, 8'h20);
      program_vignette(65536, 65536, 255, 0, 255);
      send_pixel(12'd0, 12'd0, 8'h99, 8'h12, 8'h34, 8'h56);
      send_pixel(12'd1, 12'd1, 8'hAA, 8'h65, 8'h43, 8'h21);
   endtask

   task automatic test_unmapped_register();
      program_vignette(65536 / 100, 65536 / 80, 200, 100, 50);
      write_register(UNMAPPED_LOW, 32'hFFFF_FFFF);
      write_register(UNMAPPED_HIGH, 32'hFFFF_FFFF);
      release_bus();
      send_pixel(12'd5, 12'd70, 8'hBB, 8'h0F, 8'hF0, 8'h3C);
      send_pixel(12'd50, 12'd40, 8'hCC, 8'hC3, 8'h5A, 8'hA5);
   endtask

   task automatic test_random_frames(int count, int gap_pct, int hold_pct);
      int sent;
      int frame_w;
      int frame_h;
      int burst;
      logic [31:0] inv_w;
      logic [31:0] inv_h;
      send_gap_pct = gap_pct;
      stall_pct = hold_pct;
      sent = 0;
      while (sent < count) begin
         frame_w = pick_extent();
         frame_h = pick_extent();
         inv_w = 65536 / frame_w;
         inv_h = 65536 / frame_h;
         if ($urandom_range(9) == 0) begin
            inv_w = $urandom_range(32'h1FFFF);
            frame_w = 4096;
         end
         if ($urandom_range(9) == 0) begin
            inv_h = $urandom_range(32'h1FFFF);
            frame_h = 4096;
         end
         program_vignette(inv_w, inv_h, pick_tint(), pick_tint(), pick_tint());
         burst = $urandom_range(20, 80);
         repeat (burst) begin
            send_pixel(pick_coord(frame_w), pick_coord(frame_h),
                       8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            sent++;
         end
      end
   endtask

   initial begin
      build_weight_curve();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_center_and_corners();
      test_beyond_frame();
      test_zero_inverse();
      test_unmapped_register();
      test_random_frames(550, 16, 48);
      test_random_frames(550, 48, 16);
      test_random_frames(550, 0, 0);
      quiesce();
      if (mismatch_count == 0) begin
         $display("pixel_vignette_blend test passed");
      end else begin
         $display("pixel_vignette_blend test failed");
      end
      $finish;
   end

endmodule
